@@ design/rau_pkg.sv @@
`default_nettype none
package rau_pkg;
  localparam int unsigned OperandWidthDefault = 32;
  localparam int unsigned DataWidth = 64;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4,
    KIND_RED = 3'd5,
    KIND_NONE6 = 3'd6,
    KIND_NONE7 = 3'd7
  } kind_e;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBadOperand = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;

  localparam logic [1:0] OrdLess = 2'd0;
  localparam logic [1:0] OrdEqual = 2'd1;
  localparam logic [1:0] OrdGreater = 2'd2;
  localparam logic [1:0] OrdInvalid = 2'd3;

  // request to the reduction unit
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } red_req_t;

  // answer of the reduction unit
  typedef struct packed {
    logic        done;
    logic [63:0] num;
    logic [63:0] den;
  } red_rsp_t;
endpackage
`default_nettype wire

@@ design/rau_reduce.sv @@
`default_nettype none
// reduces a fraction: binary gcd of magnitudes, then two restoring divisions,
// all through one shared 64-bit subtractor
module rau_reduce (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rau_pkg::red_req_t req_i,
  output rau_pkg::red_rsp_t      rsp_o
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_e;

  state_e      state_q;
  logic [63:0] a_q, b_q;        // gcd working pair
  logic [5:0]  sh_q;            // common factor of two
  logic [63:0] g_q;             // gcd
  logic [63:0] nmag_q, dmag_q;
  logic        neg_q;
  logic [63:0] quo_q;           // quotient being formed
  logic [63:0] rem_q;           // partial remainder
  logic [5:0]  bit_q;
  logic [63:0] rn_q, rd_q;

  logic [63:0] nmag_in, dmag_in;
  logic [63:0] sub_a, sub_b, diff;
  logic        borrow;
  logic [64:0] rem_sh;
  logic [63:0] dividend;

  assign nmag_in = req_i.num[63] ? (64'd0 - req_i.num) : req_i.num;
  assign dmag_in = req_i.den[63] ? (64'd0 - req_i.den) : req_i.den;
  assign dividend = (state_q == S_DIVN) ? nmag_q : dmag_q;
  assign rem_sh = {rem_q, dividend[bit_q]};

  // shared subtractor
  always_comb begin
    if (state_q == S_GCD) begin
      sub_a = (a_q >= b_q) ? a_q : b_q;
      sub_b = (a_q >= b_q) ? b_q : a_q;
    end else begin
      sub_a = rem_sh[63:0];
      sub_b = g_q;
    end
  end
  assign diff = sub_a - sub_b;
  assign borrow = (state_q == S_GCD) ? 1'b0 : (!rem_sh[64] && (rem_sh[63:0] < g_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            a_q <= nmag_in;
            b_q <= dmag_in;
            sh_q <= '0;
            nmag_q <= nmag_in;
            dmag_q <= dmag_in;
            neg_q <= req_i.num[63] ^ req_i.den[63];
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          // stein steps: one halving or one subtraction per cycle
          if (a_q == 64'd0 || b_q == 64'd0) begin
            g_q <= ((a_q | b_q) == 64'd0) ? 64'd1 : ((a_q | b_q) << sh_q);
            rem_q <= '0;
            quo_q <= '0;
            bit_q <= 6'd63;
            state_q <= S_DIVN;
          end else if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            sh_q <= sh_q + 6'd1;
          end else if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else begin
            a_q <= diff;
            b_q <= sub_b;
          end
        end
        S_DIVN, S_DIVD: begin
          // one quotient bit per cycle
          if (bit_q == 6'd0) begin
            if (state_q == S_DIVN) begin
              rn_q <= borrow ? {quo_q[62:0], 1'b0} : {quo_q[62:0], 1'b1};
              rem_q <= '0;
              quo_q <= '0;
              bit_q <= 6'd63;
              state_q <= S_DIVD;
            end else begin
              rd_q <= borrow ? {quo_q[62:0], 1'b0} : {quo_q[62:0], 1'b1};
              state_q <= S_DONE;
            end
          end else begin
            if (borrow) begin
              rem_q <= rem_sh[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end else begin
              rem_q <= diff;
              quo_q <= {quo_q[62:0], 1'b1};
            end
            bit_q <= bit_q - 6'd1;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done = (state_q == S_DONE);
  assign rsp_o.num = neg_q ? (64'd0 - rn_q) : rn_q;
  assign rsp_o.den = rd_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (state_q == S_IDLE))
    else $error("reduce done not single cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVN && bit_q == 6'd0) |=> (state_q == S_DIVD))
    else $error("denominator division skipped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVN) |-> (g_q != 64'd0))
    else $error("zero gcd used as divisor");
endmodule
`default_nettype wire

@@ design/rational_arithmetic_unit.sv @@
`default_nettype none
// add, sub, mul and div form the cross products, then reduce the result through the gcd unit;
// reduce goes straight to the gcd unit; compare runs two reductions and two products
// invalid operands and unused kinds go straight to the result without computing
// one word at a time: the next is taken in the cycle after the result leaves
// reset: asynchronous, active low; clears the sequencer and the output valid flag
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // first_num, first_den, second_num, second_den (lowest bits first)
  input  wire logic [127:0] s_axis_tdata,
  // kind
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_num, result_den (lowest bits first)
  output logic [127:0]      m_axis_tdata,
  // status, order (lowest bits first)
  output logic [3:0]        m_axis_tuser
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RED1, S_START2, S_RED2, S_CMP, S_CMP2, S_OUT
  } state_e;

  state_e      state_q;
  kind_e       kind_q;
  logic signed [63:0] n1_q, d1_q, n2_q, d2_q;
  logic signed [63:0] pa_q, pb_q, pc_q;
  logic [1:0]  mul_step_q;
  logic [63:0] an_q, ad_q;
  logic [1:0]  st_q, ord_q;
  logic [63:0] rn_q, rd_q;
  logic        out_v_q;

  red_req_t req;
  red_rsp_t rsp;

  function automatic logic signed [63:0] sext(input logic [31:0] v);
    logic signed [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return 64'(t);
  endfunction

  logic signed [63:0] f_n1, f_d1, f_n2, f_d2;
  assign f_n1 = sext(s_axis_tdata[31:0]);
  assign f_d1 = sext(s_axis_tdata[63:32]);
  assign f_n2 = sext(s_axis_tdata[95:64]);
  assign f_d2 = sext(s_axis_tdata[127:96]);

  // one shared 33x33 signed multiplier, operands chosen by step
  logic signed [63:0] ma, mb;
  always_comb begin
    ma = n1_q; mb = d2_q;
    unique case (mul_step_q)
      2'd0: begin ma = n1_q; mb = (kind_q == KIND_MUL) ? n2_q : d2_q; end
      2'd1: begin ma = n2_q; mb = d1_q; end
      2'd2: begin ma = d1_q; mb = (kind_q == KIND_DIV) ? n2_q : d2_q; end
      default: begin ma = an_q; mb = ad_q; end
    endcase
  end

  logic signed [65:0] prod_w;
  assign prod_w = $signed(ma[32:0]) * $signed(mb[32:0]);

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign req.start = (state_q == S_MUL && mul_step_q == 2'd3) || (state_q == S_START2);
  assign req.num = (state_q == S_START2) ? n2_q :
                   (kind_q == KIND_ADD) ? (pa_q + pb_q) :
                   (kind_q == KIND_SUB) ? (pa_q - pb_q) :
                   (kind_q == KIND_CMP || kind_q == KIND_RED) ? n1_q : pa_q;
  assign req.den = (state_q == S_START2) ? d2_q :
                   (kind_q == KIND_CMP || kind_q == KIND_RED) ? d1_q : pc_q;

  rau_reduce u_reduce (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  logic signed [63:0] cx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q <= kind_e'(s_axis_tuser);
            n1_q <= f_n1; d1_q <= f_d1; n2_q <= f_n2; d2_q <= f_d2;
            st_q <= StOk; ord_q <= OrdLess; rn_q <= '0; rd_q <= '0;
            mul_step_q <= 2'd0;
            state_q <= S_OUT;
            if (s_axis_tuser <= 3'(KIND_CMP)) begin
              if (f_d1 == 0 || f_d2 == 0) begin
                st_q <= StBadOperand;
                if (s_axis_tuser == 3'(KIND_CMP)) ord_q <= OrdInvalid;
              end else if (s_axis_tuser == 3'(KIND_DIV) && f_n2 == 0) begin
                st_q <= StDivZero;
              end else if (s_axis_tuser == 3'(KIND_CMP)) begin
                mul_step_q <= 2'd3;
                state_q <= S_MUL;
              end else begin
                state_q <= S_MUL;
              end
            end else if (s_axis_tuser == 3'(KIND_RED)) begin
              if (f_d1 == 0) begin
                st_q <= StBadOperand; rn_q <= f_n1;
              end else begin
                mul_step_q <= 2'd3;
                state_q <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          // cross products, one per cycle
          unique case (mul_step_q)
            2'd0: pa_q <= prod_w[63:0];
            2'd1: pb_q <= prod_w[63:0];
            2'd2: pc_q <= prod_w[63:0];
            default: ;
          endcase
          if (mul_step_q == 2'd3) state_q <= S_RED1;
          else mul_step_q <= mul_step_q + 2'd1;
        end
        S_RED1: begin
          if (rsp.done) begin
            if (kind_q == KIND_CMP) begin
              an_q <= rsp.num; ad_q <= rsp.den;
              state_q <= S_START2;
            end else begin
              rn_q <= rsp.num; rd_q <= rsp.den;
              state_q <= S_OUT;
            end
          end
        end
        S_START2: begin
          // reducer is idle again, second fraction goes in
          state_q <= S_RED2;
        end
        S_RED2: begin
          if (rsp.done) begin
            // a_n * b_d next on the multiplier, a_d and b_n kept for the other product
            d1_q <= ad_q; ad_q <= rsp.den; n2_q <= rsp.num;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          cx_q <= prod_w[63:0];
          an_q <= n2_q; ad_q <= d1_q;
          state_q <= S_CMP2;
        end
        S_CMP2: begin
          // b_n * a_d on the multiplier
          ord_q <= (cx_q < $signed(prod_w[63:0])) ? OrdLess :
                   (cx_q == $signed(prod_w[63:0])) ? OrdEqual : OrdGreater;
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {rd_q, rn_q};
  assign m_axis_tuser = {ord_q, st_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> m_axis_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3:2] == OrdInvalid) |-> (m_axis_tuser[1:0] == StBadOperand))
    else $error("invalid order without bad status");
endmodule
`default_nettype wire

@@ verif/rational_arithmetic_unit_test.sv @@
`default_nettype none
module rational_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [1:0]  order;
    logic [63:0] num;
    logic [63:0] den;
  } fraction_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  fraction_result_t pending_results[$];
  int unsigned      mismatches;
  bit               steady_flow;

  rational_arithmetic_unit uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // euclid on magnitudes
  function automatic bit [63:0] common_divisor(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    while (b != 64'd0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // lowest terms with the sign on the numerator
  function automatic void lowest_terms(bit [63:0] n, bit [63:0] d,
                                       output bit [63:0] on, output bit [63:0] od);
    bit        nneg;
    bit        dneg;
    bit [63:0] nmag;
    bit [63:0] dmag;
    bit [63:0] g;
    nneg = n[63];
    dneg = d[63];
    nmag = nneg ? 64'd0 - n : n;
    dmag = dneg ? 64'd0 - d : d;
    g = common_divisor(nmag, dmag);
    if (g == 64'd0) g = 64'd1;
    nmag = nmag / g;
    dmag = dmag / g;
    on = (nneg != dneg) ? 64'd0 - nmag : nmag;
    od = dmag;
  endfunction

  function automatic fraction_result_t predict_fraction(kind_e kind, int n1, int d1,
                                                        int n2, int d2);
    fraction_result_t r;
    longint    num;
    longint    den;
    bit [63:0] an, ad, bn, bd;
    longint    x, y;
    r = '{StOk, OrdLess, 64'd0, 64'd0};
    case (kind)
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        if (d1 == 0 || d2 == 0) begin
          r.status = StBadOperand;
        end else if (kind == KIND_DIV && n2 == 0) begin
          r.status = StDivZero;
        end else begin
          case (kind)
            KIND_ADD: begin
              num = longint'(n1) * d2 + longint'(n2) * d1;
              den = longint'(d1) * d2;
            end
            KIND_SUB: begin
              num = longint'(n1) * d2 - longint'(n2) * d1;
              den = longint'(d1) * d2;
            end
            KIND_MUL: begin
              num = longint'(n1) * n2;
              den = longint'(d1) * d2;
            end
            default: begin
              num = longint'(n1) * d2;
              den = longint'(d1) * n2;
            end
          endcase
          lowest_terms(num, den, an, ad);
          r.num = an;
          r.den = ad;
        end
      end
      KIND_CMP: begin
        if (d1 == 0 || d2 == 0) begin
          r.status = StBadOperand;
          r.order  = OrdInvalid;
        end else begin
          lowest_terms(longint'(n1), longint'(d1), an, ad);
          lowest_terms(longint'(n2), longint'(d2), bn, bd);
          x = longint'(an) * longint'(bd);
          y = longint'(bn) * longint'(ad);
          r.order = (x < y) ? OrdLess : ((x == y) ? OrdEqual : OrdGreater);
        end
      end
      KIND_RED: begin
        if (d1 == 0) begin
          r.status = StBadOperand;
          r.num    = longint'(n1);
        end else begin
          lowest_terms(longint'(n1), longint'(d1), an, ad);
          r.num = an;
          r.den = ad;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // send one word, waiting a random gap first unless in steady flow
  task automatic send_word(kind_e kind, int n1, int d1, int n2, int d2);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {d2, n2, d1, n1};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_fraction(kind, n1, d1, n2, d2));
  endtask

  // result side back-pressure
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    fraction_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[1:0] !== want.status)
          report_mismatch("status", m_axis_tuser[1:0], want.status);
        if (m_axis_tuser[3:2] !== want.order)
          report_mismatch("order", m_axis_tuser[3:2], want.order);
        if (m_axis_tdata[63:0] !== want.num)
          report_mismatch("result_num", m_axis_tdata[63:0], want.num);
        if (m_axis_tdata[127:64] !== want.den)
          report_mismatch("result_den", m_axis_tdata[127:64], want.den);
      end
    end
  end

  function automatic int pick_operand();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      1, 2, 3: return $urandom_range(0, 40) - 20;
      4, 5:    return ($urandom_range(0, 2000) - 1000) * (1 << $urandom_range(0, 12));
      default: return $urandom;
    endcase
  endfunction

  // extremes of each field for every operation
  task automatic test_extremes();
    kind_e k;
    for (int i = 0; i < 8; i++) begin
      k = kind_e'(i);
      send_word(k, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      send_word(k, 32'sh7fff_ffff, -1, 32'sh8000_0000, 32'sh8000_0000);
    end
  endtask

  // named corner cases
  task automatic test_special_cases();
    send_word(KIND_ADD, 1, 0, 2, 3);                 // zero first denominator
    send_word(KIND_MUL, 1, 2, 3, 0);                 // zero second denominator
    send_word(KIND_DIV, 5, 7, 0, 9);                 // division by zero fraction
    send_word(KIND_CMP, 1, 2, 2, 4);                 // equal
    send_word(KIND_CMP, -1, 2, 1, 3);                // less
    send_word(KIND_CMP, 3, -4, 1, 0);                // invalid operand
    send_word(KIND_RED, -12345, 0, 9, 9);            // reduce of invalid value
    send_word(KIND_RED, 0, -5, 0, 0);                // zero over negative
    // sum wraps past two to the 63, reduces to minus two
    send_word(KIND_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_word(KIND_SUB, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
  endtask

  task automatic test_random(int count);
    kind_e k;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      k = kind_e'($urandom_range(0, 19) < 18 ? $urandom_range(0, 5) : $urandom_range(6, 7));
      send_word(k, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    steady_flow = 1'b0;
  endtask

  // run limit
  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mismatches    = 0;
    steady_flow   = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_ADD;
    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_random(1480);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (700) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
